// ===== rtl/fpa_pkg.sv =====
// fpa_pkg: action codes and shared constants of the fixed-point alu
// no dependencies
package fpa_pkg;

    localparam int WORD_W        = 32;
    localparam int ACT_W         = 4;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [ACT_W-1:0] ACT_ADD      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SUB      = 4'd1;
    localparam logic [ACT_W-1:0] ACT_MUL      = 4'd2;
    localparam logic [ACT_W-1:0] ACT_DIV      = 4'd3;
    localparam logic [ACT_W-1:0] ACT_MIN      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_MAX      = 4'd5;
    localparam logic [ACT_W-1:0] ACT_INC      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_DEC      = 4'd7;
    localparam logic [ACT_W-1:0] ACT_TO_INT   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_FROM_INT = 4'd9;

endpackage

// ===== rtl/fixed_point_alu.sv =====
// fixed_point_alu: pipelined signed fixed-point alu with exact rounding divide
// depends on fpa_pkg
//
// throughput: one request per cycle; the whole pipe advances together and
//   holds when the output register is full and not taken
// the pipe length is set by the divider: one restoring step per quotient bit
// reset: synchronous active-low i_rst_n clears all valid bits
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [fpa_pkg::ACT_W-1:0]          i_action,
    input  logic signed [fpa_pkg::WORD_W-1:0]  i_operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0]  i_operand_b,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [fpa_pkg::WORD_W-1:0]  o_result,
    output logic                               o_less,
    output logic                               o_equal,
    output logic                               o_greater,
    output logic                               o_overflow,
    output logic                               o_div_by_zero
);
    import fpa_pkg::*;

    // numerator |a| << FRAC_BITS and the quotient both need this many bits
    localparam int NW = WORD_W + FRAC_BITS;
    // stage 0 decode, stage 1 multiply rounding, then NW divide steps
    localparam int NS = NW + 2;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             is_div;   // divide with a nonzero divisor
        logic [31:0]      res;
        logic             ovf;
        logic             dz;
        logic             lt;
        logic             eq;
        logic             gt;
        logic             neg;      // sign of the divide quotient
        logic [31:0]      den;      // divisor magnitude
        logic [NW-1:0]    num;      // numerator, consumed msb first
        logic [NW-1:0]    quo;
        logic [31:0]      rem;
    } t_item;

    // saturate a 33-bit signed sum into 32 bits, {ovf, value}
    function automatic logic [32:0] sat33(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return {1'b1, (s[32] ? SAT_MIN : SAT_MAX)};
        end
        return {1'b0, s[31:0]};
    endfunction

    // apply sign to a magnitude and saturate, {ovf, value}
    function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > 64'h8000_0000) begin
                return {1'b1, SAT_MIN};
            end
            return {1'b0, 32'd0 - m[31:0]};
        end
        if (m > 64'h7FFF_FFFF) begin
            return {1'b1, SAT_MAX};
        end
        return {1'b0, m[31:0]};
    endfunction

    t_item                r_st  [NS];
    logic [NS-1:0]        r_vld;
    logic signed [63:0]   r_prod;
    t_item                r_out;
    logic                 r_out_vld;
    logic                 w_en;

    // whole pipe moves when the output register is free or being taken
    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    // ---------------- stage 0: decode, simple actions, multiplier ----------------
    t_item              n_s0;
    logic signed [63:0] n_prod;

    always_comb begin
        logic [32:0]        sum;
        logic [32:0]        dif;
        logic [32:0]        inc;
        logic [32:0]        dec;
        logic signed [63:0] fi;
        logic [31:0]        abs_a;
        logic [32:0]        sr;
        n_s0     = '0;
        n_prod   = 64'(i_operand_a) * 64'(i_operand_b);
        sum      = {i_operand_a[31], i_operand_a} + {i_operand_b[31], i_operand_b};
        dif      = {i_operand_a[31], i_operand_a} - {i_operand_b[31], i_operand_b};
        inc      = {i_operand_a[31], i_operand_a} + 33'd1;
        dec      = {i_operand_a[31], i_operand_a} - 33'd1;
        fi       = 64'(i_operand_a) <<< FRAC_BITS;
        abs_a    = i_operand_a[31] ? 32'd0 - i_operand_a : i_operand_a;
        sr       = '0;
        n_s0.act = i_action;
        n_s0.lt  = i_operand_a < i_operand_b;
        n_s0.eq  = i_operand_a == i_operand_b;
        n_s0.gt  = i_operand_a > i_operand_b;
        n_s0.neg = i_operand_a[31] ^ i_operand_b[31];
        n_s0.den = i_operand_b[31] ? 32'd0 - i_operand_b : i_operand_b;
        n_s0.num = NW'(abs_a) << FRAC_BITS;
        case (i_action)
            ACT_ADD: begin
                sr = sat33(sum);
            end
            ACT_SUB: begin
                sr = sat33(dif);
            end
            ACT_INC: begin
                sr = sat33(inc);
            end
            ACT_DEC: begin
                sr = sat33(dec);
            end
            ACT_MIN: begin
                sr = {1'b0, (n_s0.lt ? i_operand_a : i_operand_b)};
            end
            ACT_MAX: begin
                sr = {1'b0, (n_s0.gt ? i_operand_a : i_operand_b)};
            end
            ACT_TO_INT: begin
                sr = {1'b0, 32'(i_operand_a >>> FRAC_BITS)};
            end
            ACT_FROM_INT: begin
                if (fi[63:31] != {33{fi[63]}}) begin
                    sr = {1'b1, (fi[63] ? SAT_MIN : SAT_MAX)};
                end else begin
                    sr = {1'b0, fi[31:0]};
                end
            end
            ACT_DIV: begin
                n_s0.dz     = (i_operand_b == '0);
                n_s0.is_div = (i_operand_b != '0);
                sr          = '0;
            end
            default: begin
                sr = '0;
            end
        endcase
        n_s0.ovf = sr[32];
        n_s0.res = sr[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0] <= n_s0;
            r_prod  <= n_prod;
        end
    end

    // ---------------- stage 1: multiply rounding and saturation ----------------
    t_item n_s1;

    always_comb begin
        logic [63:0] mag;
        logic [63:0] mr;
        logic [32:0] sr;
        n_s1 = r_st[0];
        mag  = r_prod[63] ? 64'd0 - r_prod : r_prod;
        // round half away from zero on the magnitude
        mr   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        sr   = sat_mag(mr, r_prod[63]);
        if (r_st[0].act == ACT_MUL) begin
            n_s1.ovf = sr[32];
            n_s1.res = sr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[1] <= n_s1;
        end
    end

    // ---------------- divide: one restoring step per stage ----------------
    for (genvar k = 0; k < NW; k++) begin : g_div
        t_item       n_st;
        logic [32:0] w_trial;
        logic        w_take;

        assign w_trial = {r_st[k+1].rem, r_st[k+1].num[NW-1]};
        assign w_take  = w_trial >= {1'b0, r_st[k+1].den};

        always_comb begin
            n_st     = r_st[k+1];
            n_st.num = r_st[k+1].num << 1;
            n_st.quo = {r_st[k+1].quo[NW-2:0], w_take};
            n_st.rem = w_take ? 32'(w_trial - {1'b0, r_st[k+1].den}) : w_trial[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_st[k+2] <= n_st;
            end
        end
    end

    // ---------------- final: quotient rounding, output register ----------------
    t_item n_out;

    always_comb begin
        logic        rnd;
        logic [NW:0] m;
        logic [32:0] sr;
        n_out = r_st[NS-1];
        // round half away from zero: add one when 2 * remainder >= divisor
        rnd   = {r_st[NS-1].rem, 1'b0} >= {1'b0, r_st[NS-1].den};
        m     = {1'b0, r_st[NS-1].quo} + (NW+1)'(rnd);
        sr    = sat_mag(64'(m), r_st[NS-1].neg);
        if (r_st[NS-1].is_div) begin
            n_out.ovf = sr[32];
            n_out.res = sr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NS-2:0], i_valid};
            r_out_vld <= r_vld[NS-1];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result      = r_out.res;
    assign o_less        = r_out.lt;
    assign o_equal       = r_out.eq;
    assign o_greater     = r_out.gt;
    assign o_overflow    = r_out.ovf;
    assign o_div_by_zero = r_out.dz;

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for the fixed-point alu
// depends on fpa_pkg and fixed_point_alu
`timescale 1ns / 1ps

module tb;
    import fpa_pkg::*;

    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int LATENCY = 32 + FRAC + 3;
    localparam int N_RAND  = 1500;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [WORD_W-1:0] op_a;
        logic signed [WORD_W-1:0] op_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic less;
        logic equal;
        logic greater;
        logic overflow;
        logic div_by_zero;
    } alu_res_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [ACT_W-1:0]         i_action;
    logic signed [WORD_W-1:0] i_operand_a;
    logic signed [WORD_W-1:0] i_operand_b;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [WORD_W-1:0] o_result;
    logic o_less, o_equal, o_greater, o_overflow, o_div_by_zero;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    int  n_mismatch  = 0;
    int  n_checked   = 0;
    int  n_sent      = 0;
    bit  stim_done   = 0;
    bit  quiet_phase = 0;   // no random idling on either side
    int  hold_cycles = 0;   // receiver hold-off counter
    int  op_hits[16];

    fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // clamp to 32 bits, flag saturation
    function automatic logic [WORD_W:0] saturate(longint v);
        if (v > MAX32) return {1'b1, 32'h7fff_ffff};
        if (v < MIN32) return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    // exact fixed-point arithmetic, 64-bit intermediate
    function automatic alu_res_t alu_predict(alu_req_t rq);
        alu_res_t   r;
        longint     a, b, p;
        longint unsigned m, num, d, one;
        logic [WORD_W:0] s;
        a   = rq.op_a;
        b   = rq.op_b;
        one = 64'd1 << FRAC;
        s   = '0;
        r   = '0;
        case (rq.action)
            ACT_ADD: s = saturate(a + b);
            ACT_SUB: s = saturate(a - b);
            ACT_MUL: begin
                p = a * b;
                m = ((p < 0 ? -p : p) + (one >> 1)) >> FRAC;
                s = saturate(p < 0 ? -longint'(m) : longint'(m));
            end
            ACT_DIV: begin
                if (b == 0) begin
                    r.div_by_zero = 1'b1;
                end else begin
                    num = (a < 0 ? -a : a) << FRAC;
                    d   = b < 0 ? -b : b;
                    m   = (2 * num + d) / (2 * d);
                    s   = saturate(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
                end
            end
            ACT_MIN: s = {1'b0, (a < b ? rq.op_a : rq.op_b)};
            ACT_MAX: s = {1'b0, (a > b ? rq.op_a : rq.op_b)};
            ACT_INC: s = saturate(a + 1);
            ACT_DEC: s = saturate(a - 1);
            ACT_TO_INT: s = {1'b0, rq.op_a >>> FRAC};   // floor
            ACT_FROM_INT: s = saturate(a * longint'(one));
            default: s = '0;   // unused codes give zero
        endcase
        r.result   = s[WORD_W-1:0];
        r.overflow = s[WORD_W];
        r.less     = a < b;
        r.equal    = a == b;
        r.greater  = a > b;
        return r;
    endfunction

    // operand mix: extremes, small values, near-overflow, full random
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
            3: return 32'($signed($urandom_range(0, 8192)) - 4096);
            4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            5: return 32'($urandom_range(0, 255)) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(logic [ACT_W-1:0] act, logic [31:0] a, logic [31:0] b);
        alu_req_t rq;
        rq.action = act;
        rq.op_a   = a;
        rq.op_b   = b;
        pending_reqs.push_back(rq);
    endtask

    // driver: valid stays up with a stable payload until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_action    <= '0;
            i_operand_a <= '0;
            i_operand_b <= '0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                n_sent <= n_sent + 1;
                op_hits[i_action] <= op_hits[i_action] + 1;
                expected_results.push_back(
                    alu_predict({i_action, i_operand_a, i_operand_b}));
            end
            if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 26)) begin
                alu_req_t rq;
                rq = pending_reqs.pop_front();
                i_valid     <= 1'b1;
                i_action    <= rq.action;
                i_operand_a <= rq.op_a;
                i_operand_b <= rq.op_b;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to fill the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= quiet_phase || $urandom_range(0, 99) >= 26;
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            alu_res_t got, exp_r;
            got = {o_result, o_less, o_equal, o_greater, o_overflow, o_div_by_zero};
            if (expected_results.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("unexpected result %h with nothing pending", got);
            end else begin
                exp_r = expected_results.pop_front();
                n_checked <= n_checked + 1;
                if (got !== exp_r) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10) begin
                        $display("mismatch: result exp %h got %h", exp_r.result, got.result);
                        $display("  lt/eq/gt/ovf/dz exp %b%b%b%b%b got %b%b%b%b%b",
                            exp_r.less, exp_r.equal, exp_r.greater, exp_r.overflow,
                            exp_r.div_by_zero, got.less, got.equal, got.greater,
                            got.overflow, got.div_by_zero);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        foreach (op_hits[k]) op_hits[k] = 0;

        // directed: every action, extremes, divide by zero, unused codes
        push_req(ACT_ADD, 32'h7fff_ffff, 32'h0000_0001);
        push_req(ACT_ADD, 32'h8000_0000, 32'hffff_ffff);
        push_req(ACT_SUB, 32'h8000_0000, 32'h0000_0001);
        push_req(ACT_SUB, 32'h7fff_ffff, 32'h8000_0000);
        push_req(ACT_MUL, 32'h0000_0180, 32'hffff_ff80);
        push_req(ACT_MUL, 32'h8000_0000, 32'h8000_0000);
        push_req(ACT_MUL, 32'h0000_0001, 32'h0000_0080);   // half rounds away
        push_req(ACT_DIV, 32'h0000_0100, 32'h0000_0000);
        push_req(ACT_DIV, 32'h8000_0000, 32'h0000_0000);
        push_req(ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
        push_req(ACT_DIV, 32'h0000_0001, 32'hffff_fe00);
        push_req(ACT_DIV, 32'h7fff_ffff, 32'h0000_0001);
        push_req(ACT_MIN, 32'h8000_0000, 32'h7fff_ffff);
        push_req(ACT_MAX, 32'h8000_0000, 32'h7fff_ffff);
        push_req(ACT_MIN, 32'h0000_0005, 32'h0000_0005);
        push_req(ACT_INC, 32'h7fff_ffff, 32'h0);
        push_req(ACT_DEC, 32'h8000_0000, 32'h0);
        push_req(ACT_TO_INT, 32'hffff_ff01, 32'h0);
        push_req(ACT_TO_INT, 32'h7fff_ffff, 32'h1);
        push_req(ACT_FROM_INT, 32'h0080_0000, 32'h0);
        push_req(ACT_FROM_INT, 32'hff80_0000, 32'h0);
        push_req(4'd10, 32'h1, 32'h2);
        push_req(4'd15, 32'h3, 32'h2);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // long receiver hold-off while the sender keeps offering requests
        @(posedge i_clk);
        hold_cycles <= 4 * LATENCY;
        for (int n = 0; n < N_RAND; n++) begin
            if (n == 600) begin
                while (pending_reqs.size() != 0) @(posedge i_clk);
                quiet_phase = 1'b1;
            end
            if (n == 800) begin
                while (pending_reqs.size() != 0) @(posedge i_clk);
                quiet_phase = 1'b0;
            end
            push_req($urandom_range(0, 99) < 3 ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9)),
                     pick_operand(), pick_operand());
        end

        while (pending_reqs.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d results from %0d requests, all ten actions plus unused codes",
            n_checked, n_sent);
        $display("add %0d mul %0d div %0d to_int %0d from_int %0d, long output hold-off included",
            op_hits[ACT_ADD], op_hits[ACT_MUL], op_hits[ACT_DIV], op_hits[ACT_TO_INT],
            op_hits[ACT_FROM_INT]);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout, %0d results still pending", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
